// ===== hdl/mau_pkg.sv =====
// Shared types, codes and default sizes of the matrix arithmetic unit.
package mau_pkg;

   localparam int MAX_DIM_DEFAULT       = 8;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH           = 32;
   localparam int INDEX_WIDTH           = 3;
   localparam int OP_WIDTH              = 3;
   localparam int CSR_INDEX_WIDTH       = 2;
   localparam int CSR_DATA_WIDTH        = 4;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_LOAD_A    = 3'd0,
      OP_LOAD_B    = 3'd1,
      OP_ADD       = 3'd2,
      OP_SUBTRACT  = 3'd3,
      OP_MULTIPLY  = 3'd4,
      OP_TRANSPOSE = 3'd5,
      OP_COMPARE   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_MUL  = 2'd2,
      MODE_PASS = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } csr_type;

   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      mode_type mode;
   } issue_type;

   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] row;
      logic [INDEX_WIDTH-1:0] col;
      logic                   last;
      logic                   equal_flag;
      logic                   size_error;
      logic                   element;
   } emit_type;

endpackage

// ===== hdl/mau_channels.sv =====
// Handshake channel interfaces of the matrix arithmetic unit.
interface mau_req_if import mau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [OP_WIDTH-1:0]           operation;
   logic [INDEX_WIDTH-1:0]        row_index;
   logic [INDEX_WIDTH-1:0]        col_index;
   logic signed [FIELD_WIDTH-1:0] element_value;

   modport source (output valid, output operation, output row_index, output col_index,
                   output element_value, input ready);
   modport sink (input valid, input operation, input row_index, input col_index,
                 input element_value, output ready);
endinterface

interface mau_rsp_if import mau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [INDEX_WIDTH-1:0]        out_row;
   logic [INDEX_WIDTH-1:0]        out_col;
   logic signed [FIELD_WIDTH-1:0] out_value;
   logic                          last;
   logic                          equal_flag;
   logic                          size_error;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output last, output equal_flag, output size_error, input ready);
   modport sink (input valid, input out_row, input out_col, input out_value,
                 input last, input equal_flag, input size_error, output ready);
endinterface

interface mau_csr_if import mau_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [CSR_DATA_WIDTH-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== hdl/matrix_arithmetic_unit.sv =====
// Top level of the matrix arithmetic unit: sequencer, element store, shared MAC, output register.
//
//   channel  port    direction  payload
//   request  req_ch  in         operation, row_index, col_index, element_value
//   result   rsp_ch  out        out_row, out_col, out_value, last, equal_flag, size_error
//   config   csr_ch  in         reg_index, write_data (rows_a, cols_a, rows_b, cols_b)
//
// A load item writes one element and leaves the block ready. Each result element of add,
// subtract or transpose passes once through the single multiply-accumulate pipeline,
// and each element of multiply passes rows_b inner terms through it; compare gives one
// result, as does a size error. Reset is synchronous and sets every size to one.
// A stalled result holds the sequencer before the next element; no item is taken
// until a run has placed its last result in the output register.
module matrix_arithmetic_unit import mau_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mau_req_if.sink   req_ch,
   mau_rsp_if.source rsp_ch,
   mau_csr_if.sink   csr_ch
);

   localparam int EW = (ELEMENT_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : ELEMENT_WIDTH;
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

   logic                 we_a;
   logic                 we_b;
   logic [AW-1:0]        waddr;
   logic [AW-1:0]        raddr_a;
   logic [AW-1:0]        raddr_b;
   logic signed [EW-1:0] rdata_a;
   logic signed [EW-1:0] rdata_b;
   logic                 mac_done;
   logic                 acc_zero;
   logic signed [EW-1:0] sat_value;
   logic                 out_free;
   issue_type            issue;
   emit_type             emit;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0]        out_row_ff, out_row_in;
   logic [INDEX_WIDTH-1:0]        out_col_ff, out_col_in;
   logic signed [FIELD_WIDTH-1:0] out_value_ff, out_value_in;
   logic                          last_ff, last_in;
   logic                          equal_flag_ff, equal_flag_in;
   logic                          size_error_ff, size_error_in;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   mau_seq #(
      .MAX_DIM (MAX_DIM)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .req_row       (req_ch.row_index),
      .req_col       (req_ch.col_index),
      .csr_valid     (csr_ch.valid),
      .csr_index     (csr_ch.reg_index),
      .csr_data      (csr_ch.write_data),
      .out_free      (out_free),
      .mac_done      (mac_done),
      .acc_zero      (acc_zero),
      .we_a          (we_a),
      .we_b          (we_b),
      .waddr         (waddr),
      .raddr_a       (raddr_a),
      .raddr_b       (raddr_b),
      .issue         (issue),
      .emit          (emit)
   );

   mau_store #(
      .MAX_DIM (MAX_DIM),
      .EW      (EW)
   ) u_store (
      .clock   (clock),
      .we_a    (we_a),
      .we_b    (we_b),
      .waddr   (waddr),
      .wdata   (req_ch.element_value[EW-1:0]),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   mau_mac #(
      .EW (EW)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b),
      .done      (mac_done),
      .acc_zero  (acc_zero),
      .sat_value (sat_value)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_value_in  = out_value_ff;
      last_in       = last_ff;
      equal_flag_in = equal_flag_ff;
      size_error_in = size_error_ff;
      if (emit.valid) begin
         rsp_valid_in  = 1'b1;
         out_row_in    = emit.row;
         out_col_in    = emit.col;
         out_value_in  = emit.element ? FIELD_WIDTH'(sat_value) : '0;
         last_in       = emit.last;
         equal_flag_in = emit.equal_flag;
         size_error_in = emit.size_error;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_value_ff  <= out_value_in;
      last_ff       <= last_in;
      equal_flag_ff <= equal_flag_in;
      size_error_ff <= size_error_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_row    = out_row_ff;
   assign rsp_ch.out_col    = out_col_ff;
   assign rsp_ch.out_value  = out_value_ff;
   assign rsp_ch.last       = last_ff;
   assign rsp_ch.equal_flag = equal_flag_ff;
   assign rsp_ch.size_error = size_error_ff;

endmodule

// ===== hdl/mau_store.sv =====
// Element memories for matrices A and B with registered read ports.
module mau_store import mau_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   parameter int EW      = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 we_a,
   input  logic                 we_b,
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] waddr,
   input  logic [EW-1:0]        wdata,
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_a,
   input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_b,
   output logic signed [EW-1:0] rdata_a,
   output logic signed [EW-1:0] rdata_b
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic [EW-1:0] mem_a [DEPTH];
   logic [EW-1:0] mem_b [DEPTH];
   logic [EW-1:0] rdata_a_ff;
   logic [EW-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[waddr] <= wdata;
      end
      if (we_b) begin
         mem_b[waddr] <= wdata;
      end
      rdata_a_ff <= mem_a[raddr_a];
      rdata_b_ff <= mem_b[raddr_b];
   end

   assign rdata_a = signed'(rdata_a_ff);
   assign rdata_b = signed'(rdata_b_ff);

endmodule

// ===== hdl/mau_mac.sv =====
// Shared pipelined multiply, add, subtract and accumulate unit with output saturation.
module mau_mac import mau_pkg::*; #(
   parameter int EW = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  issue_type            issue,
   input  logic signed [EW-1:0] rdata_a,
   input  logic signed [EW-1:0] rdata_b,
   output logic                 done,
   output logic                 acc_zero,
   output logic signed [EW-1:0] sat_value
);

   localparam int ACC_W = 2 * EW + 5;
   localparam logic signed [ACC_W-1:0] VMAX = (ACC_W'(1) << (EW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] VMIN = -VMAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);

   issue_type s1_ff, s1_in;
   issue_type s2_ff, s2_in;
   issue_type s3_ff, s3_in;
   logic      done_ff, done_in;

   logic signed [ACC_W-1:0]  term_ff, term_in;
   logic signed [ACC_W-1:0]  rterm_ff, rterm_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  a_ext;
   logic signed [ACC_W-1:0]  b_ext;
   logic signed [2*EW-1:0]   prod;

   always_comb begin
      s1_in   = issue;
      s2_in   = s1_ff;
      s3_in   = s2_ff;
      done_in = s3_ff.valid && s3_ff.last;

      a_ext = ACC_W'(rdata_a);
      b_ext = ACC_W'(rdata_b);
      prod  = rdata_a * rdata_b;

      case (s1_ff.mode)
         MODE_ADD: begin
            term_in = a_ext + b_ext;
         end
         MODE_SUB: begin
            term_in = a_ext - b_ext;
         end
         MODE_MUL: begin
            term_in = ACC_W'(prod);
         end
         default: begin
            term_in = a_ext;
         end
      endcase

      if (s2_ff.mode == MODE_MUL) begin
         rterm_in = (term_ff + ROUND_BIAS) >>> 16;
      end else begin
         rterm_in = term_ff;
      end

      acc_in = acc_ff;
      if (s3_ff.valid) begin
         if (s3_ff.first) begin
            acc_in = rterm_ff;
         end else begin
            acc_in = acc_ff + rterm_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      rterm_ff <= rterm_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      if (acc_ff > VMAX) begin
         sat_value = VMAX[EW-1:0];
      end else if (acc_ff < VMIN) begin
         sat_value = VMIN[EW-1:0];
      end else begin
         sat_value = acc_ff[EW-1:0];
      end
   end

   assign done     = done_ff;
   assign acc_zero = (acc_ff == '0);

endmodule

// ===== hdl/mau_seq.sv =====
// Sequencer that walks result elements and inner terms and holds the size registers.
module mau_seq import mau_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_WIDTH-1:0]        req_operation,
   input  logic [INDEX_WIDTH-1:0]     req_row,
   input  logic [INDEX_WIDTH-1:0]     req_col,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       out_free,
   input  logic                       mac_done,
   input  logic                       acc_zero,
   output logic                       we_a,
   output logic                       we_b,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] waddr,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_a,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr_b,
   output issue_type                  issue,
   output emit_type                   emit
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      KIND_ELEM = 2'd0,
      KIND_ERR  = 2'd1,
      KIND_CMP  = 2'd2
   } kind_type;

   state_type                 state_ff, state_in;
   kind_type                  kind_ff, kind_in;
   op_type                    op_ff, op_in;
   logic [IW-1:0]             i_ff, i_in;
   logic [IW-1:0]             j_ff, j_in;
   logic [IW-1:0]             t_ff, t_in;
   logic [DW-1:0]             ni_ff, ni_in;
   logic [DW-1:0]             nj_ff, nj_in;
   logic [DW-1:0]             nk_ff, nk_in;
   logic                      eq_ff, eq_in;
   logic [CSR_DATA_WIDTH-1:0] rows_a_ff, rows_a_in;
   logic [CSR_DATA_WIDTH-1:0] cols_a_ff, cols_a_in;
   logic [CSR_DATA_WIDTH-1:0] rows_b_ff, rows_b_in;
   logic [CSR_DATA_WIDTH-1:0] cols_b_ff, cols_b_in;

   logic [DW-1:0] ra, ca, rb, cb;
   logic          i_last, j_last, t_last;
   logic          accept;
   logic          in_range;
   logic          same_size;
   mode_type      mode;

   function automatic logic [DW-1:0] dim_of(input logic [CSR_DATA_WIDTH-1:0] r);
      if (r == '0) begin
         return DW'(1);
      end else if (int'(r) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end else begin
         return DW'(r);
      end
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
      return AW'(int'(row) * MAX_DIM + int'(col));
   endfunction

   assign ra        = dim_of(rows_a_ff);
   assign ca        = dim_of(cols_a_ff);
   assign rb        = dim_of(rows_b_ff);
   assign cb        = dim_of(cols_b_ff);
   assign same_size = (ra == rb) && (ca == cb);
   assign i_last    = (DW'(i_ff) + DW'(1)) == ni_ff;
   assign j_last    = (DW'(j_ff) + DW'(1)) == nj_ff;
   assign t_last    = (DW'(t_ff) + DW'(1)) == nk_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign waddr     = AW'(int'(req_row) * MAX_DIM + int'(req_col));

   always_comb begin
      case (op_ff)
         OP_ADD: begin
            mode = MODE_ADD;
         end
         OP_SUBTRACT, OP_COMPARE: begin
            mode = MODE_SUB;
         end
         OP_MULTIPLY: begin
            mode = MODE_MUL;
         end
         default: begin
            mode = MODE_PASS;
         end
      endcase

      case (op_ff)
         OP_MULTIPLY: begin
            raddr_a = addr_of(i_ff, t_ff);
            raddr_b = addr_of(t_ff, j_ff);
         end
         OP_TRANSPOSE: begin
            raddr_a = addr_of(j_ff, i_ff);
            raddr_b = addr_of(j_ff, i_ff);
         end
         default: begin
            raddr_a = addr_of(i_ff, j_ff);
            raddr_b = addr_of(i_ff, j_ff);
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      op_in     = op_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      ni_in     = ni_ff;
      nj_in     = nj_ff;
      nk_in     = nk_ff;
      eq_in     = eq_ff;
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      we_a      = 1'b0;
      we_b      = 1'b0;
      issue     = '0;
      emit      = '0;

      if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_ROWS_A: begin
               rows_a_in = csr_data;
            end
            CSR_COLS_A: begin
               cols_a_in = csr_data;
            end
            CSR_ROWS_B: begin
               rows_b_in = csr_data;
            end
            CSR_COLS_B: begin
               cols_b_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = op_type'(req_operation);
               kind_in = KIND_ELEM;
               i_in    = '0;
               j_in    = '0;
               t_in    = '0;
               nk_in   = DW'(1);
               case (op_type'(req_operation))
                  OP_LOAD_A: begin
                     we_a = in_range;
                  end
                  OP_LOAD_B: begin
                     we_b = in_range;
                  end
                  OP_ADD, OP_SUBTRACT: begin
                     ni_in = ra;
                     nj_in = ca;
                     if (same_size) begin
                        state_in = S_ISSUE;
                     end else begin
                        kind_in  = KIND_ERR;
                        state_in = S_EMIT;
                     end
                  end
                  OP_MULTIPLY: begin
                     ni_in = ra;
                     nj_in = cb;
                     nk_in = rb;
                     if (ca == rb) begin
                        state_in = S_ISSUE;
                     end else begin
                        kind_in  = KIND_ERR;
                        state_in = S_EMIT;
                     end
                  end
                  OP_TRANSPOSE: begin
                     ni_in    = ca;
                     nj_in    = ra;
                     state_in = S_ISSUE;
                  end
                  OP_COMPARE: begin
                     ni_in = ra;
                     nj_in = ca;
                     eq_in = same_size;
                     if (same_size) begin
                        state_in = S_ISSUE;
                     end else begin
                        kind_in  = KIND_CMP;
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ISSUE: begin
            issue.valid = 1'b1;
            issue.first = (t_ff == '0);
            issue.last  = t_last;
            issue.mode  = mode;
            if (t_last) begin
               t_in     = '0;
               state_in = S_WAIT;
            end else begin
               t_in = t_ff + IW'(1);
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               if (op_ff == OP_COMPARE) begin
                  eq_in = eq_ff && acc_zero;
                  if (i_last && j_last) begin
                     kind_in  = KIND_CMP;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_ISSUE;
                     if (j_last) begin
                        j_in = '0;
                        i_in = i_ff + IW'(1);
                     end else begin
                        j_in = j_ff + IW'(1);
                     end
                  end
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit.valid      = 1'b1;
               emit.element    = (kind_ff == KIND_ELEM);
               emit.size_error = (kind_ff == KIND_ERR);
               emit.equal_flag = (kind_ff == KIND_CMP) && eq_ff;
               if (kind_ff == KIND_ELEM) begin
                  emit.row  = INDEX_WIDTH'(i_ff);
                  emit.col  = INDEX_WIDTH'(j_ff);
                  emit.last = i_last && j_last;
               end else begin
                  emit.last = 1'b1;
               end
               if ((kind_ff == KIND_ELEM) && !(i_last && j_last)) begin
                  state_in = S_ISSUE;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + IW'(1);
                  end else begin
                     j_in = j_ff + IW'(1);
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kind_ff   <= KIND_ELEM;
         op_ff     <= OP_LOAD_A;
         i_ff      <= '0;
         j_ff      <= '0;
         t_ff      <= '0;
         ni_ff     <= DW'(1);
         nj_ff     <= DW'(1);
         nk_ff     <= DW'(1);
         eq_ff     <= 1'b0;
         rows_a_ff <= CSR_DATA_WIDTH'(1);
         cols_a_ff <= CSR_DATA_WIDTH'(1);
         rows_b_ff <= CSR_DATA_WIDTH'(1);
         cols_b_ff <= CSR_DATA_WIDTH'(1);
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         op_ff     <= op_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         t_ff      <= t_in;
         ni_ff     <= ni_in;
         nj_ff     <= nj_in;
         nk_ff     <= nk_in;
         eq_ff     <= eq_in;
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         rows_b_ff <= rows_b_in;
         cols_b_ff <= cols_b_in;
      end
   end

endmodule

// ===== hdl/mau_checker.sv =====
// Port-level assertions for the matrix arithmetic unit and their binding.
module mau_port_assertions import mau_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [OP_WIDTH-1:0]           req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [FIELD_WIDTH-1:0] rsp_out_value,
   input logic                          rsp_last,
   input logic                          rsp_equal_flag,
   input logic                          rsp_size_error
);

   logic req_accept;
   logic is_load;
   logic is_compute;

   assign req_accept = req_valid && req_ready;
   assign is_load    = (req_operation == OP_LOAD_A) || (req_operation == OP_LOAD_B);
   assign is_compute = (req_operation == OP_ADD) || (req_operation == OP_SUBTRACT) ||
                       (req_operation == OP_MULTIPLY) || (req_operation == OP_TRANSPOSE) ||
                       (req_operation == OP_COMPARE);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A stalled result item was dropped.");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_compute |=> !req_ready)
      else $error("The block took a new item while a run was starting.");

   a_ready_after_load: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_load |=> req_ready)
      else $error("A load item left the block busy.");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> rsp_last && !rsp_equal_flag && (rsp_out_value == '0))
      else $error("A size error result carried data or was not the last item.");

   a_equal_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal_flag |-> rsp_last && !rsp_size_error && (rsp_out_value == '0))
      else $error("An equality result was not a single final item.");

endmodule

bind matrix_arithmetic_unit mau_port_assertions u_mau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_operation  (req_ch.operation),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_value  (rsp_ch.out_value),
   .rsp_last       (rsp_ch.last),
   .rsp_equal_flag (rsp_ch.equal_flag),
   .rsp_size_error (rsp_ch.size_error)
);
